FILE: src/bf16_rotary_pair_rotate_top_defines.svh
// assertion macros for the bf16 rotary pair rotate block
`ifndef BF16_ROTARY_PAIR_ROTATE_TOP_DEFINES_SVH
`define BF16_ROTARY_PAIR_ROTATE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BRPR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("brpr assertion failed");

// next-cycle implication, always checked
`define BRPR_ASSERT_NXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("brpr assertion failed");

`endif

FILE: src/brpr_pkg.sv
// types and constants for the bf16 rotary pair rotate block
`timescale 1ns / 1ps
`default_nettype none
package brpr_pkg;

  localparam int Latency = 6;
  localparam logic [15:0] QnanBf16 = 16'h7FC0;
  localparam logic [30:0] InfMag = 31'h7F800000;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_FIN,
    CLS_INF,
    CLS_NAN
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic               sign;
    logic [15:0]        m;
    logic signed [11:0] e;
  } term_t;

  typedef struct packed {
    term_t x;
    term_t y;
  } s1_t;

  typedef struct packed {
    logic               spec;
    logic               nan;
    logic [31:0]        fbits;
    logic               sub;
    logic               sx;
    logic               sy;
    logic [55:0]        a;
    logic [55:0]        b;
    logic signed [11:0] u;
  } s2_t;

  typedef struct packed {
    logic               spec;
    logic               nan;
    logic [31:0]        fbits;
    logic               sign;
    logic [56:0]        m;
    logic signed [11:0] u;
  } s3_t;

  typedef struct packed {
    logic               spec;
    logic               nan;
    logic [31:0]        fbits;
    logic               sign;
    logic [56:0]        m;
    logic signed [11:0] u;
    logic [5:0]         lz;
  } s4_t;

  typedef struct packed {
    logic               spec;
    logic               nan;
    logic [31:0]        fbits;
    logic               sign;
    logic [56:0]        mn;
    logic signed [11:0] lead;
  } s5_t;

endpackage
`default_nettype wire

FILE: src/bf16_rotary_pair_rotate_top.sv
// top level: bf16 rotary pair rotation, six-stage pipeline
`timescale 1ns / 1ps
`default_nettype none
// Takes one request per cycle while start is high and busy is low (busy is
// high only in reset). Each request gives one result, shown for one cycle
// with done high; the receiver cannot stall, so the pipeline never holds.
// Stages: decode and 8x8 products, operand swap and alignment, wide add,
// leading-zero count, normalize, round to fp32 then bf16. The user sets
// conj_mode through cfg_we / cfg_data while no request is in flight (not enforced).
module bf16_rotary_pair_rotate_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] first_elem,
  input  wire logic [15:0] second_elem,
  input  wire logic [15:0] cos_val,
  input  wire logic [15:0] sin_val,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  output logic             done,
  output logic [15:0]      first_out,
  output logic [15:0]      second_out
);

  function automatic brpr_pkg::term_t dec(logic [15:0] h);
    brpr_pkg::term_t t;
    logic [7:0] ex;
    logic [6:0] fr;
    logic [2:0] sh;
    ex = h[14:7];
    fr = h[6:0];
    sh = 3'd0;
    t.sign = h[15];
    t.m = '0;
    t.e = '0;
    t.cls = brpr_pkg::CLS_FIN;
    if (ex == 8'hFF) begin
      t.cls = (fr != 7'd0) ? brpr_pkg::CLS_NAN : brpr_pkg::CLS_INF;
    end else if (ex == 8'd0) begin
      if (fr == 7'd0) begin
        t.cls = brpr_pkg::CLS_ZERO;
      end else begin
        for (int i = 0; i < 7; i++) begin
          if (fr[i]) sh = 3'(7 - i);
        end
        t.m = {8'd0, 8'({1'b0, fr} << sh)};
        t.e = -12'sd133 - $signed({9'd0, sh});
      end
    end else begin
      t.m = {8'd0, 1'b1, fr};
      t.e = $signed({4'd0, ex}) - 12'sd134;
    end
    return t;
  endfunction

  function automatic brpr_pkg::term_t tmul(brpr_pkg::term_t x, brpr_pkg::term_t y);
    brpr_pkg::term_t t;
    t.sign = x.sign ^ y.sign;
    t.m = '0;
    t.e = '0;
    if (x.cls == brpr_pkg::CLS_NAN || y.cls == brpr_pkg::CLS_NAN) begin
      t.cls = brpr_pkg::CLS_NAN;
    end else if ((x.cls == brpr_pkg::CLS_INF && y.cls == brpr_pkg::CLS_ZERO) ||
                 (x.cls == brpr_pkg::CLS_ZERO && y.cls == brpr_pkg::CLS_INF)) begin
      t.cls = brpr_pkg::CLS_NAN;
    end else if (x.cls == brpr_pkg::CLS_INF || y.cls == brpr_pkg::CLS_INF) begin
      t.cls = brpr_pkg::CLS_INF;
    end else if (x.cls == brpr_pkg::CLS_ZERO || y.cls == brpr_pkg::CLS_ZERO) begin
      t.cls = brpr_pkg::CLS_ZERO;
    end else begin
      t.cls = brpr_pkg::CLS_FIN;
      t.m = 16'(x.m[7:0] * y.m[7:0]);
      t.e = x.e + y.e;
    end
    return t;
  endfunction

  function automatic brpr_pkg::s2_t align(brpr_pkg::term_t x0, brpr_pkg::term_t y0);
    brpr_pkg::s2_t r;
    brpr_pkg::term_t x;
    brpr_pkg::term_t y;
    logic bzero;
    logic [11:0] d;
    logic [11:0] sh;
    r = '0;
    x = x0;
    y = y0;
    bzero = 1'b0;
    d = '0;
    sh = '0;
    if (x0.cls == brpr_pkg::CLS_NAN || y0.cls == brpr_pkg::CLS_NAN) begin
      r.spec = 1'b1;
      r.nan = 1'b1;
    end else if (x0.cls == brpr_pkg::CLS_INF && y0.cls == brpr_pkg::CLS_INF) begin
      r.spec = 1'b1;
      r.nan = x0.sign != y0.sign;
      r.fbits = {x0.sign, brpr_pkg::InfMag};
    end else if (x0.cls == brpr_pkg::CLS_INF) begin
      r.spec = 1'b1;
      r.fbits = {x0.sign, brpr_pkg::InfMag};
    end else if (y0.cls == brpr_pkg::CLS_INF) begin
      r.spec = 1'b1;
      r.fbits = {y0.sign, brpr_pkg::InfMag};
    end else if (x0.cls == brpr_pkg::CLS_ZERO && y0.cls == brpr_pkg::CLS_ZERO) begin
      r.spec = 1'b1;
      r.fbits = {x0.sign & y0.sign, 31'd0};
    end else begin
      if (y0.cls == brpr_pkg::CLS_ZERO) begin
        bzero = 1'b1;
      end else if (x0.cls == brpr_pkg::CLS_ZERO) begin
        x = y0;
        y = x0;
        bzero = 1'b1;
      end else if (y0.e > x0.e) begin
        x = y0;
        y = x0;
      end
      d = 12'(x.e - y.e);
      r.a = {x.m, 40'd0};
      if (bzero) begin
        r.b = '0;
      end else if (d <= 12'd40) begin
        r.b = 56'(y.m) << 6'(12'd40 - d);
      end else begin
        sh = d - 12'd40;
        if (sh >= 12'd16) begin
          r.b = 56'd1;
        end else begin
          r.b = 56'(y.m >> sh[3:0]) |
                56'(|(16'(y.m << (5'd16 - {1'b0, sh[3:0]}))));
        end
      end
      r.sub = x.sign ^ y.sign;
      r.sx = x.sign;
      r.sy = y.sign;
      r.u = x.e - 12'sd40;
    end
    return r;
  endfunction

  function automatic brpr_pkg::s3_t addsub(brpr_pkg::s2_t p);
    brpr_pkg::s3_t r;
    r.spec = p.spec;
    r.nan = p.nan;
    r.fbits = p.fbits;
    r.u = p.u;
    if (!p.sub) begin
      r.m = {1'b0, p.a} + {1'b0, p.b};
      r.sign = p.sx;
    end else if (p.a >= p.b) begin
      r.m = {1'b0, p.a - p.b};
      r.sign = p.sx;
    end else begin
      r.m = {1'b0, p.b - p.a};
      r.sign = p.sy;
    end
    if (!p.spec && r.m == 57'd0) begin
      r.spec = 1'b1;
      r.nan = 1'b0;
      r.fbits = '0;
    end
    return r;
  endfunction

  function automatic logic [5:0] lzc(logic [56:0] m);
    logic [5:0] z;
    z = 6'd0;
    for (int i = 0; i < 57; i++) begin
      if (m[i]) z = 6'(56 - i);
    end
    return z;
  endfunction

  function automatic logic [15:0] rnd(brpr_pkg::s5_t p);
    logic [31:0] f;
    logic [32:0] fr;
    logic signed [11:0] k;
    logic signed [11:0] q;
    logic signed [11:0] biased;
    logic [5:0] sh;
    logic [24:0] mant;
    logic guard;
    logic sticky;
    logic [15:0] res;
    f = '0;
    k = '0;
    q = '0;
    biased = '0;
    sh = '0;
    mant = '0;
    guard = 1'b0;
    sticky = 1'b0;
    if (p.spec) begin
      f = p.fbits;
    end else if (p.lead > 12'sd127) begin
      f = {p.sign, brpr_pkg::InfMag};
    end else begin
      if (p.lead < -12'sd126) begin
        k = p.lead + 12'sd150;
        q = -12'sd149;
      end else begin
        k = 12'sd24;
        q = p.lead - 12'sd23;
      end
      if (k < 12'sd0) begin
        f = {p.sign, 31'd0};
      end else begin
        sh = 6'(12'sd57 - k);
        mant = 25'(p.mn >> sh);
        guard = p.mn[sh - 6'd1];
        sticky = |(57'(p.mn << (6'd58 - sh)));
        if (guard && (sticky || mant[0])) mant = mant + 25'd1;
        if (mant[24]) begin
          mant = mant >> 1;
          q = q + 12'sd1;
        end
        if (mant[23]) begin
          biased = q + 12'sd150;
          if (biased >= 12'sd255) begin
            f = {p.sign, brpr_pkg::InfMag};
          end else begin
            f = {p.sign, biased[7:0], mant[22:0]};
          end
        end else begin
          f = {p.sign, 8'd0, mant[22:0]};
        end
      end
    end
    if (p.nan || (f[30:23] == 8'hFF && f[22:0] != 23'd0)) begin
      res = brpr_pkg::QnanBf16;
    end else begin
      fr = {1'b0, f} + 33'h7FFF + {32'd0, f[16]};
      res = fr[31:16];
    end
    return res;
  endfunction

  logic conj_mode;
  logic [brpr_pkg::Latency-2:0] vld;
  brpr_pkg::s1_t s1 [2];
  brpr_pkg::s2_t s2 [2];
  brpr_pkg::s3_t s3 [2];
  brpr_pkg::s4_t s4 [2];
  brpr_pkg::s5_t s5 [2];
  brpr_pkg::s1_t s1_next [2];
  brpr_pkg::term_t a_co, c_si, a_si, c_co, c_si_n, a_si_n;

  assign busy = rst;

  always_comb begin
    a_co = tmul(dec(first_elem), dec(cos_val));
    c_si = tmul(dec(second_elem), dec(sin_val));
    a_si = tmul(dec(first_elem), dec(sin_val));
    c_co = tmul(dec(second_elem), dec(cos_val));
    c_si_n = c_si;
    c_si_n.sign = ~c_si.sign;
    a_si_n = a_si;
    a_si_n.sign = ~a_si.sign;
    if (conj_mode) begin
      s1_next[0] = '{x: a_co, y: c_si};
      s1_next[1] = '{x: c_co, y: a_si_n};
    end else begin
      s1_next[0] = '{x: a_co, y: c_si_n};
      s1_next[1] = '{x: a_si, y: c_co};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conj_mode <= 1'b0;
      vld <= '0;
      done <= 1'b0;
    end else begin
      if (cfg_we) conj_mode <= cfg_data;
      vld <= {vld[brpr_pkg::Latency-3:0], start & ~busy};
      done <= vld[brpr_pkg::Latency-2];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      s1[l] <= s1_next[l];
      s2[l] <= align(s1[l].x, s1[l].y);
      s3[l] <= addsub(s2[l]);
      s4[l] <= '{spec: s3[l].spec, nan: s3[l].nan, fbits: s3[l].fbits,
                 sign: s3[l].sign, m: s3[l].m, u: s3[l].u, lz: lzc(s3[l].m)};
      s5[l] <= '{spec: s4[l].spec, nan: s4[l].nan, fbits: s4[l].fbits,
                 sign: s4[l].sign, mn: s4[l].m << s4[l].lz,
                 lead: s4[l].u + 12'sd56 - $signed({6'd0, s4[l].lz})};
    end
    first_out <= rnd(s5[0]);
    second_out <= rnd(s5[1]);
  end

endmodule
`default_nettype wire

FILE: src/brpr_checker.sv
// port-level checker for the bf16 rotary pair rotate block, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "bf16_rotary_pair_rotate_top_defines.svh"
module brpr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  `BRPR_ASSERT_IMP(a_req_gives_done, clk, rst, start && !busy, ##6 done)
  `BRPR_ASSERT_IMP(a_done_has_req, clk, rst, done, $past(start && !busy, 6))
  `BRPR_ASSERT_NXT(a_rst_clears_done, clk, rst, !done)

endmodule

bind bf16_rotary_pair_rotate_top brpr_checker u_brpr_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done)
);
`default_nettype wire
